### rtl/core/sliding_mode_attitude_law_core_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sliding mode attitude law core
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef SLIDING_MODE_ATTITUDE_LAW_CORE_MACROS_SVH
`define SLIDING_MODE_ATTITUDE_LAW_CORE_MACROS_SVH

// same-cycle implication
`define SMAL_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("smal: same-cycle check failed");

// next-cycle implication
`define SMAL_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("smal: next-cycle check failed");

`endif

### rtl/core/smal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smal_pkg
// Widths, register indexes, carried side data and fixed-point helpers.
// ----------------------------------------------------------------------------
package smal_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DW        = 32;
  localparam int PW        = 2 * DW;
  localparam int SW        = PW + 2;
  localparam int RW        = PW - FRAC_BITS + 1;
  localparam int QW        = FRAC_BITS + 1;
  localparam int DVW       = DW + 1 + FRAC_BITS;
  localparam int SQ_STEPS  = DW;
  localparam int REMW      = DW + 4;
  localparam int SHW       = $clog2(DW);
  localparam int IDXW      = 8;
  localparam int KCONST    = (2 ** FRAC_BITS + 50) / 100;

  localparam logic [IDXW-1:0] CFG_ROLL_INT_GAIN   = IDXW'(0);
  localparam logic [IDXW-1:0] CFG_ROLL_ANG_GAIN   = IDXW'(1);
  localparam logic [IDXW-1:0] CFG_PITCH_INT_GAIN  = IDXW'(2);
  localparam logic [IDXW-1:0] CFG_PITCH_ANG_GAIN  = IDXW'(3);

  localparam logic signed [SW-1:0] C3_BIAS = SW'(20) <<< FRAC_BITS;

  typedef struct packed {
    logic signed [RW-1:0] lin_r;
    logic signed [RW-1:0] lin_p;
    logic                 neg_r;
    logic                 neg_p;
    logic                 zero;
  } tail_t;

  typedef struct packed {
    tail_t          tail;
    logic [DW-1:0]  mag_r;
    logic [DW-1:0]  mag_p;
  } sq_side_t;

  function automatic logic signed [PW-1:0] sat64(input logic signed [SW-1:0] x);
    if (x[SW-1:PW-1] == {(SW-PW+1){x[SW-1]}}) begin
      sat64 = x[PW-1:0];
    end else begin
      sat64 = x[SW-1] ? {1'b1, {(PW-1){1'b0}}} : {1'b0, {(PW-1){1'b1}}};
    end
  endfunction

  function automatic logic signed [DW-1:0] sat32(input logic signed [SW-1:0] x);
    if (x[SW-1:DW-1] == {(SW-DW+1){x[SW-1]}}) begin
      sat32 = x[DW-1:0];
    end else begin
      sat32 = x[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  endfunction

  // drop FRAC_BITS fraction bits, half rounds up
  function automatic logic signed [RW-1:0] rnd(input logic signed [PW-1:0] x);
    logic signed [PW-1:0] fl;
    fl  = x >>> FRAC_BITS;
    rnd = fl[RW-1:0] + RW'(x[FRAC_BITS-1]);
  endfunction

endpackage

### rtl/core/smal_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smal_front
// Surfaces, coefficients, linear term, normalization and sum of squares.
// ----------------------------------------------------------------------------
module smal_front import smal_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [DW-1:0] roll_int_gain_i,
  input  logic signed [DW-1:0] roll_ang_gain_i,
  input  logic signed [DW-1:0] pitch_int_gain_i,
  input  logic signed [DW-1:0] pitch_ang_gain_i,
  input  logic signed [DW-1:0] roll_integral_error_i,
  input  logic signed [DW-1:0] pitch_integral_error_i,
  input  logic signed [DW-1:0] roll_angle_i,
  input  logic signed [DW-1:0] pitch_angle_i,
  input  logic signed [DW-1:0] roll_rate_i,
  input  logic signed [DW-1:0] pitch_rate_i,
  output logic                 valid_o,
  output logic [PW-1:0]        rad_o,
  output sq_side_t             side_o
);

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_q;

  // stage 1
  logic signed [PW-1:0] pe_r_q, pa_r_q, g12_r_q, g22_r_q;
  logic signed [PW-1:0] pe_p_q, pa_p_q, g12_p_q, g22_p_q;
  logic signed [DW-1:0] rt_r_q, rt_p_q, g1_r_q, g2_r_q, g1_p_q, g2_p_q;
  logic signed [DW-1:0] e1_r_q, a1_r_q, e1_p_q, a1_p_q;
  // stage 2
  logic signed [DW-1:0] s_r_q, s_p_q, c1_r_q, c2_r_q, c3_r_q, c1_p_q, c2_p_q, c3_p_q;
  logic signed [DW-1:0] e2_r_q, a2_r_q, e2_p_q, a2_p_q;
  logic signed [DW-1:0] s_r_d, s_p_d;
  // stage 3
  logic signed [PW-1:0] m1_r_q, m2_r_q, m3_r_q, m1_p_q, m2_p_q, m3_p_q;
  logic [DW-1:0]        mag_r_q, mag_p_q;
  logic [SHW-1:0]       sh_q;
  logic                 neg_r_q, neg_p_q, zero3_q;
  logic [DW-1:0]        mag_r_d, mag_p_d, mx_d;
  logic [SHW-1:0]       sh_d;
  // stage 4
  logic [DW-1:0]        nm_r_q, nm_p_q;
  tail_t                tail4_q, tail5_q, tail6_q;
  // stage 5
  logic [PW-1:0]        sq_r_q, sq_p_q;
  logic [DW-1:0]        nm5_r_q, nm5_p_q;
  // stage 6
  logic [PW-1:0]        rad_q;
  logic [DW-1:0]        nm6_r_q, nm6_p_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NSTG-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pe_r_q  <= roll_int_gain_i * roll_integral_error_i;
      pa_r_q  <= roll_ang_gain_i * roll_angle_i;
      g12_r_q <= roll_int_gain_i * roll_ang_gain_i;
      g22_r_q <= roll_ang_gain_i * roll_ang_gain_i;
      pe_p_q  <= pitch_int_gain_i * pitch_integral_error_i;
      pa_p_q  <= pitch_ang_gain_i * pitch_angle_i;
      g12_p_q <= pitch_int_gain_i * pitch_ang_gain_i;
      g22_p_q <= pitch_ang_gain_i * pitch_ang_gain_i;
      rt_r_q  <= roll_rate_i;
      rt_p_q  <= pitch_rate_i;
      g1_r_q  <= roll_int_gain_i;
      g2_r_q  <= roll_ang_gain_i;
      g1_p_q  <= pitch_int_gain_i;
      g2_p_q  <= pitch_ang_gain_i;
      e1_r_q  <= roll_integral_error_i;
      a1_r_q  <= roll_angle_i;
      e1_p_q  <= pitch_integral_error_i;
      a1_p_q  <= pitch_angle_i;
    end
  end

  assign s_r_d = sat32(SW'(rnd(sat64(SW'(sat64(SW'(pe_r_q) + SW'(pa_r_q)))
                                     + (SW'(rt_r_q) <<< FRAC_BITS)))));
  assign s_p_d = sat32(SW'(rnd(sat64(SW'(sat64(SW'(pe_p_q) + SW'(pa_p_q)))
                                     + (SW'(rt_p_q) <<< FRAC_BITS)))));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_r_q  <= s_r_d;
      s_p_q  <= s_p_d;
      c1_r_q <= sat32(SW'(rnd(g12_r_q)));
      c2_r_q <= sat32(SW'(g1_r_q) + SW'(rnd(g22_r_q)));
      c3_r_q <= sat32(SW'(g2_r_q) + C3_BIAS);
      c1_p_q <= sat32(SW'(rnd(g12_p_q)));
      c2_p_q <= sat32(SW'(g1_p_q) + SW'(rnd(g22_p_q)));
      c3_p_q <= sat32(SW'(g2_p_q) + C3_BIAS);
      e2_r_q <= e1_r_q;
      a2_r_q <= a1_r_q;
      e2_p_q <= e1_p_q;
      a2_p_q <= a1_p_q;
    end
  end

  assign mag_r_d = s_r_q[DW-1] ? DW'(-s_r_q) : DW'(s_r_q);
  assign mag_p_d = s_p_q[DW-1] ? DW'(-s_p_q) : DW'(s_p_q);
  assign mx_d    = (mag_r_d >= mag_p_d) ? mag_r_d : mag_p_d;

  // shift that brings the larger magnitude up to bit DW-2
  always_comb begin
    sh_d = '0;
    for (int i = 0; i < DW - 1; i++) begin
      if (mx_d[i]) sh_d = SHW'(DW - 2 - i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m1_r_q  <= c1_r_q * e2_r_q;
      m2_r_q  <= c2_r_q * a2_r_q;
      m3_r_q  <= c3_r_q * s_r_q;
      m1_p_q  <= c1_p_q * e2_p_q;
      m2_p_q  <= c2_p_q * a2_p_q;
      m3_p_q  <= c3_p_q * s_p_q;
      mag_r_q <= mag_r_d;
      mag_p_q <= mag_p_d;
      sh_q    <= sh_d;
      neg_r_q <= s_r_q[DW-1];
      neg_p_q <= s_p_q[DW-1];
      zero3_q <= (s_r_q == '0) && (s_p_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tail4_q.lin_r <= rnd(sat64(SW'(sat64(SW'(m1_r_q) + SW'(m2_r_q))) - SW'(m3_r_q)));
      tail4_q.lin_p <= rnd(sat64(SW'(sat64(SW'(m1_p_q) + SW'(m2_p_q))) - SW'(m3_p_q)));
      tail4_q.neg_r <= neg_r_q;
      tail4_q.neg_p <= neg_p_q;
      tail4_q.zero  <= zero3_q;
      nm_r_q        <= mag_r_q << sh_q;
      nm_p_q        <= mag_p_q << sh_q;
      sq_r_q        <= nm_r_q * nm_r_q;
      sq_p_q        <= nm_p_q * nm_p_q;
      nm5_r_q       <= nm_r_q;
      nm5_p_q       <= nm_p_q;
      tail5_q       <= tail4_q;
      rad_q         <= sq_r_q + sq_p_q;
      nm6_r_q       <= nm5_r_q;
      nm6_p_q       <= nm5_p_q;
      tail6_q       <= tail5_q;
    end
  end

  assign valid_o      = vld_q[NSTG-1];
  assign rad_o        = rad_q;
  assign side_o.tail  = tail6_q;
  assign side_o.mag_r = nm6_r_q;
  assign side_o.mag_p = nm6_p_q;

endmodule

### rtl/core/smal_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smal_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module smal_sqrt import smal_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [PW-1:0]  rad_i,
  input  sq_side_t       side_i,
  output logic           valid_o,
  output logic [DW-1:0]  norm_o,
  output sq_side_t       side_o
);

  logic [SQ_STEPS-1:0] vld_q;
  logic [REMW-1:0]     rem_q  [SQ_STEPS];
  logic [DW-1:0]       root_q [SQ_STEPS];
  logic [PW-1:0]       rad_q  [SQ_STEPS];
  sq_side_t            side_q [SQ_STEPS];

  for (genvar i = 0; i < SQ_STEPS; i++) begin : g_step
    logic            vin;
    logic [REMW-1:0] rin, cur, trial;
    logic [DW-1:0]   oin;
    logic [PW-1:0]   din;
    sq_side_t        sin;

    if (i == 0) begin : g_first
      assign vin = valid_i;
      assign rin = '0;
      assign oin = '0;
      assign din = rad_i;
      assign sin = side_i;
    end else begin : g_next
      assign vin = vld_q[i-1];
      assign rin = rem_q[i-1];
      assign oin = root_q[i-1];
      assign din = rad_q[i-1];
      assign sin = side_q[i-1];
    end

    assign cur   = {rin[REMW-3:0], din[PW-1:PW-2]};
    assign trial = REMW'({oin, 2'b01});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (cur >= trial) begin
          rem_q[i]  <= cur - trial;
          root_q[i] <= {oin[DW-2:0], 1'b1};
        end else begin
          rem_q[i]  <= cur;
          root_q[i] <= {oin[DW-2:0], 1'b0};
        end
        rad_q[i]  <= {din[PW-3:0], 2'b00};
        side_q[i] <= sin;
      end
    end
  end

  assign valid_o = vld_q[SQ_STEPS-1];
  assign norm_o  = root_q[SQ_STEPS-1];
  assign side_o  = side_q[SQ_STEPS-1];

endmodule

### rtl/core/smal_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smal_div
// Two-lane pipelined restoring divider: rounded magnitude over the norm.
// ----------------------------------------------------------------------------
module smal_div import smal_pkg::*; (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           en_i,
  input  logic           valid_i,
  input  logic [DW-1:0]  norm_i,
  input  sq_side_t       side_i,
  output logic           valid_o,
  output logic [QW-1:0]  quot_r_o,
  output logic [QW-1:0]  quot_p_o,
  output tail_t          tail_o
);

  logic            vld0_q;
  logic [DVW-1:0]  dvd_r_q, dvd_p_q;
  logic [DW-1:0]   n0_q;
  tail_t           tail0_q;

  logic [QW-1:0]   vld_q;
  logic [DW-1:0]   rem_r_q [QW];
  logic [DW-1:0]   rem_p_q [QW];
  logic [QW-1:0]   lo_r_q  [QW];
  logic [QW-1:0]   lo_p_q  [QW];
  logic [QW-1:0]   qt_r_q  [QW];
  logic [QW-1:0]   qt_p_q  [QW];
  logic [DW-1:0]   n_q     [QW];
  tail_t           tail_q  [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld0_q <= 1'b0;
    end else if (en_i) begin
      vld0_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dvd_r_q <= DVW'({side_i.mag_r, {FRAC_BITS{1'b0}}}) + DVW'(norm_i >> 1);
      dvd_p_q <= DVW'({side_i.mag_p, {FRAC_BITS{1'b0}}}) + DVW'(norm_i >> 1);
      n0_q    <= norm_i;
      tail0_q <= side_i.tail;
    end
  end

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic          vin;
    logic [DW-1:0] rr_in, rp_in, nin;
    logic [QW-1:0] lr_in, lp_in, qr_in, qp_in;
    tail_t         tin;
    logic [DW:0]   t_r, t_p;
    logic          ge_r, ge_p;

    if (i == 0) begin : g_first
      assign vin   = vld0_q;
      assign rr_in = dvd_r_q[DVW-1:QW];
      assign rp_in = dvd_p_q[DVW-1:QW];
      assign lr_in = dvd_r_q[QW-1:0];
      assign lp_in = dvd_p_q[QW-1:0];
      assign qr_in = '0;
      assign qp_in = '0;
      assign nin   = n0_q;
      assign tin   = tail0_q;
    end else begin : g_next
      assign vin   = vld_q[i-1];
      assign rr_in = rem_r_q[i-1];
      assign rp_in = rem_p_q[i-1];
      assign lr_in = lo_r_q[i-1];
      assign lp_in = lo_p_q[i-1];
      assign qr_in = qt_r_q[i-1];
      assign qp_in = qt_p_q[i-1];
      assign nin   = n_q[i-1];
      assign tin   = tail_q[i-1];
    end

    assign t_r  = {rr_in, lr_in[QW-1]};
    assign t_p  = {rp_in, lp_in[QW-1]};
    assign ge_r = t_r >= {1'b0, nin};
    assign ge_p = t_p >= {1'b0, nin};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i] <= 1'b0;
      end else if (en_i) begin
        vld_q[i] <= vin;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_r_q[i] <= ge_r ? DW'(t_r - {1'b0, nin}) : t_r[DW-1:0];
        rem_p_q[i] <= ge_p ? DW'(t_p - {1'b0, nin}) : t_p[DW-1:0];
        qt_r_q[i]  <= {qr_in[QW-2:0], ge_r};
        qt_p_q[i]  <= {qp_in[QW-2:0], ge_p};
        lo_r_q[i]  <= {lr_in[QW-2:0], 1'b0};
        lo_p_q[i]  <= {lp_in[QW-2:0], 1'b0};
        n_q[i]     <= nin;
        tail_q[i]  <= tin;
      end
    end
  end

  assign valid_o  = vld_q[QW-1];
  assign quot_r_o = qt_r_q[QW-1];
  assign quot_p_o = qt_p_q[QW-1];
  assign tail_o   = tail_q[QW-1];

endmodule

### rtl/core/sliding_mode_attitude_law_core.sv
// Pipeline: 6 front stages, 32 square-root stages, 18 divider stages and
//   1 output register between input request and output valid.
// Throughput: one request per cycle; every stage advances together whenever
//   the output register is empty or being taken.
// Reset: clears all valid bits and the four gain registers to zero.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_mode_attitude_law_core
// Roll/pitch sliding mode attitude law, signed fixed point, fully pipelined.
// ----------------------------------------------------------------------------
module sliding_mode_attitude_law_core import smal_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [IDXW-1:0]  cfg_index_i,
  input  logic [DW-1:0]    cfg_data_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // roll_integral_error, pitch_integral_error, roll_angle, pitch_angle,
  // roll_rate, pitch_rate
  input  logic [6*DW-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // drive_roll, drive_pitch
  output logic [2*DW-1:0]  m_axis_tdata
);

  localparam int NW = QW + 3;

  logic signed [DW-1:0] g1_r_q, g2_r_q, g1_p_q, g2_p_q;
  logic                 en;
  logic                 fr_vld, sq_vld, dv_vld;
  logic [PW-1:0]        rad;
  sq_side_t             fr_side, sq_side;
  logic [DW-1:0]        norm;
  logic [QW-1:0]        quot_r, quot_p;
  tail_t                tail;
  logic signed [NW-1:0] qv_r, qv_p, nl_r, nl_p;
  logic signed [RW:0]   sum_r, sum_p;
  logic                 out_vld_q;
  logic [2*DW-1:0]      out_data_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g1_r_q <= '0;
      g2_r_q <= '0;
      g1_p_q <= '0;
      g2_p_q <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_ROLL_INT_GAIN:  g1_r_q <= cfg_data_i;
        CFG_ROLL_ANG_GAIN:  g2_r_q <= cfg_data_i;
        CFG_PITCH_INT_GAIN: g1_p_q <= cfg_data_i;
        CFG_PITCH_ANG_GAIN: g2_p_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign en            = !out_vld_q || m_axis_tready;
  assign s_axis_tready = en;

  smal_front u_front (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .en_i                   (en),
    .valid_i                (s_axis_tvalid),
    .roll_int_gain_i        (g1_r_q),
    .roll_ang_gain_i        (g2_r_q),
    .pitch_int_gain_i       (g1_p_q),
    .pitch_ang_gain_i       (g2_p_q),
    .roll_integral_error_i  ($signed(s_axis_tdata[DW-1:0])),
    .pitch_integral_error_i ($signed(s_axis_tdata[2*DW-1:DW])),
    .roll_angle_i           ($signed(s_axis_tdata[3*DW-1:2*DW])),
    .pitch_angle_i          ($signed(s_axis_tdata[4*DW-1:3*DW])),
    .roll_rate_i            ($signed(s_axis_tdata[5*DW-1:4*DW])),
    .pitch_rate_i           ($signed(s_axis_tdata[6*DW-1:5*DW])),
    .valid_o                (fr_vld),
    .rad_o                  (rad),
    .side_o                 (fr_side)
  );

  smal_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_vld),
    .rad_i   (rad),
    .side_i  (fr_side),
    .valid_o (sq_vld),
    .norm_o  (norm),
    .side_o  (sq_side)
  );

  smal_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (sq_vld),
    .norm_i   (norm),
    .side_i   (sq_side),
    .valid_o  (dv_vld),
    .quot_r_o (quot_r),
    .quot_p_o (quot_p),
    .tail_o   (tail)
  );

  assign qv_r  = tail.neg_r ? -$signed(NW'(quot_r)) : $signed(NW'(quot_r));
  assign qv_p  = tail.neg_p ? -$signed(NW'(quot_p)) : $signed(NW'(quot_p));
  assign nl_r  = tail.zero ? '0 : -((qv_r + NW'(KCONST)) <<< 1);
  assign nl_p  = tail.zero ? '0 : -((qv_p + NW'(KCONST)) <<< 1);
  assign sum_r = (RW+1)'(tail.lin_r) + (RW+1)'(nl_r);
  assign sum_p = (RW+1)'(tail.lin_p) + (RW+1)'(nl_p);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= dv_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_q <= {sat32(SW'(sum_p)), sat32(SW'(sum_r))};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

### rtl/core/smal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smal_checker
// Port-level checks on the stream handshakes of the attitude law core.
// ----------------------------------------------------------------------------
`include "sliding_mode_attitude_law_core_macros.svh"

module smal_checker import smal_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            s_axis_tready,
  input logic            m_axis_tvalid,
  input logic            m_axis_tready,
  input logic [2*DW-1:0] m_axis_tdata
);

  `SMAL_ASSERT_NXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid)
  `SMAL_ASSERT_NXT(a_out_stable, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
  `SMAL_ASSERT_IMP(a_in_open, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready)
  `SMAL_ASSERT_IMP(a_in_stall, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, !s_axis_tready)

endmodule

bind sliding_mode_attitude_law_core smal_checker u_smal_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

### dv/sliding_mode_attitude_law_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_mode_attitude_law_core_tb
// Streams roll/pitch samples through the attitude law core under several
// gain settings and checks every drive pair against a bit-exact predictor.
// ----------------------------------------------------------------------------
module sliding_mode_attitude_law_core_tb;
  import smal_pkg::*;

  localparam logic [IDXW-1:0] CFG_UNUSED_IDX  = IDXW'(200);
  localparam logic [IDXW-1:0] CFG_FIRST_SPARE = IDXW'(4);
  localparam int DRAIN_CYCLES = 70;
  localparam int STALL_LIMIT  = 4000;
  localparam int RANDOM_PER_PHASE = 180;
  localparam longint ONE = longint'(1) << FRAC_BITS;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_valid_i = 1'b0;
  logic              cfg_ready_o;
  logic [IDXW-1:0]   cfg_index_i = '0;
  logic [DW-1:0]     cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // roll_integral_error, pitch_integral_error, roll_angle, pitch_angle,
  // roll_rate, pitch_rate
  logic [6*DW-1:0]   s_axis_tdata = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // drive_roll, drive_pitch
  logic [2*DW-1:0]   m_axis_tdata;

  logic signed [DW-1:0] gain [4] = '{default: '0};
  logic [6*DW-1:0]      pending_samples [$];
  logic [2*DW-1:0]      expected_drives [$];
  bit                   calm = 1'b0;
  int                   in_gap = 0;
  int                   out_stall = 0;
  int                   mismatches = 0;
  int                   samples_sent = 0;
  int                   drives_checked = 0;
  int                   idle_cycles = 0;

  sliding_mode_attitude_law_core dut (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic longint sat_sum(input longint a, input longint b);
    logic signed [64:0] t;
    t = {a[63], a} + {b[63], b};
    if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF) return 64'sh7FFF_FFFF_FFFF_FFFF;
    if (t < -65'sh0_8000_0000_0000_0000) return 64'sh8000_0000_0000_0000;
    return longint'(t[63:0]);
  endfunction

  function automatic longint clamp32(input longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic longint half_up(input longint x);
    return (x >>> FRAC_BITS) + longint'(x[FRAC_BITS-1]);
  endfunction

  function automatic longint unsigned int_root(input longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic [2*DW-1:0] predict_drive(input logic [6*DW-1:0] d);
    longint e, a, r, g1, g2, c1, c2, c3, acc, q;
    longint s [2];
    longint lin [2];
    longint nl [2];
    longint unsigned m [2];
    longint unsigned mx, nrm;
    logic [DW-1:0] o0, o1;
    for (int ax = 0; ax < 2; ax++) begin
      e  = longint'(signed'(d[ax*DW +: DW]));
      a  = longint'(signed'(d[(2+ax)*DW +: DW]));
      r  = longint'(signed'(d[(4+ax)*DW +: DW]));
      g1 = longint'(gain[2*ax]);
      g2 = longint'(gain[2*ax+1]);
      acc = sat_sum(sat_sum(g1 * e, g2 * a), r * ONE);
      s[ax] = clamp32(half_up(acc));
      c1 = clamp32(half_up(g1 * g2));
      c2 = clamp32(g1 + half_up(g2 * g2));
      c3 = clamp32(g2 + 20 * ONE);
      acc = sat_sum(sat_sum(c1 * e, c2 * a), -(c3 * s[ax]));
      lin[ax] = half_up(acc);
      nl[ax] = 0;
    end
    if (s[0] != 0 || s[1] != 0) begin
      m[0] = s[0] < 0 ? -s[0] : s[0];
      m[1] = s[1] < 0 ? -s[1] : s[1];
      mx = m[0] > m[1] ? m[0] : m[1];
      while (mx < (64'd1 << 30)) begin
        m[0] <<= 1;
        m[1] <<= 1;
        mx <<= 1;
      end
      nrm = int_root(m[0] * m[0] + m[1] * m[1]);
      for (int ax = 0; ax < 2; ax++) begin
        q = longint'(((m[ax] << FRAC_BITS) + nrm / 2) / nrm);
        if (s[ax] < 0) q = -q;
        nl[ax] = -2 * (q + KCONST);
      end
    end
    o0 = DW'(clamp32(lin[0] + nl[0]));
    o1 = DW'(clamp32(lin[1] + nl[1]));
    return {o1, o0};
  endfunction

  function automatic logic [DW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2, 3: return DW'(int'($urandom_range(0, 1 << 19)) - (1 << 18));
      4, 5: return DW'(int'($urandom_range(0, 1 << 23)) - (1 << 22));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [6*DW-1:0] fill(input logic [DW-1:0] v [6]);
    logic [6*DW-1:0] d;
    for (int k = 0; k < 6; k++) d[k*DW +: DW] = v[k];
    return d;
  endfunction

  task automatic report_mismatch(input string field, input logic [DW-1:0] got,
                                 input logic [DW-1:0] want);
    $display("mismatch %s: got %h expected %h (drive %0d)", field, got, want,
             drives_checked);
    mismatches++;
  endtask

  // writes stay back to back; valid only drops after the last one
  task automatic write_gains(input logic [IDXW-1:0] idx [$], input logic [DW-1:0] val [$]);
    for (int k = 0; k < idx.size(); k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i  <= val[k];
      do @(posedge clk_i); while (!cfg_ready_o);
      if (idx[k] <= CFG_PITCH_ANG_GAIN) gain[idx[k]] = val[k];
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_samples.size() != 0 || expected_drives.size() != 0 || s_axis_tvalid)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic random_phase(input logic [DW-1:0] g [4], input bit full_gain);
    logic [DW-1:0] v [6];
    write_gains('{CFG_ROLL_INT_GAIN, CFG_ROLL_ANG_GAIN, CFG_PITCH_INT_GAIN,
                  CFG_PITCH_ANG_GAIN}, '{g[0], g[1], g[2], g[3]});
    for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
      for (int k = 0; k < 6; k++) v[k] = full_gain ? $urandom : pick_value();
      pending_samples.push_back(fill(v));
    end
    wait_drained();
  endtask

  // driver
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      expected_drives.push_back(predict_drive(s_axis_tdata));
      samples_sent++;
    end
    if (!rst_ni || (s_axis_tvalid && !s_axis_tready)) begin
    end else if (in_gap > 0) begin
      in_gap--;
      s_axis_tvalid <= 1'b0;
    end else if (!calm && $urandom_range(0, 9) == 0) begin
      in_gap = $urandom_range(1, 6) - 1;
      s_axis_tvalid <= 1'b0;
    end else if (pending_samples.size() != 0) begin
      s_axis_tdata  <= pending_samples.pop_front();
      s_axis_tvalid <= 1'b1;
    end else begin
      s_axis_tvalid <= 1'b0;
    end
  end

  // monitor
  always @(posedge clk_i) begin
    logic [2*DW-1:0] want;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_drives.size() == 0) begin
        $display("unexpected drive pair %h", m_axis_tdata);
        mismatches++;
      end else begin
        want = expected_drives.pop_front();
        if (m_axis_tdata[DW-1:0] !== want[DW-1:0])
          report_mismatch("drive_roll", m_axis_tdata[DW-1:0], want[DW-1:0]);
        if (m_axis_tdata[2*DW-1:DW] !== want[2*DW-1:DW])
          report_mismatch("drive_pitch", m_axis_tdata[2*DW-1:DW], want[2*DW-1:DW]);
      end
      drives_checked++;
    end
    if (out_stall > 0) begin
      out_stall--;
      m_axis_tready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall = $urandom_range(1, 6) - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
        || (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
      $display("sliding_mode_attitude_law_core_tb: done, errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    logic [DW-1:0] g [4];
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // gains at reset: every surface is the rate alone
    pending_samples.push_back('0);
    pending_samples.push_back({6{32'h7FFF_FFFF}});
    pending_samples.push_back({6{32'h8000_0000}});
    pending_samples.push_back(fill('{0, 0, 0, 0, 32'h0001_0000, 0}));
    pending_samples.push_back(fill('{0, 0, 0, 0, 0, 32'hFFFF_FFFF}));
    wait_drained();

    // spare indexes must leave the gains alone
    write_gains('{CFG_ROLL_INT_GAIN, CFG_ROLL_ANG_GAIN, CFG_PITCH_INT_GAIN,
                  CFG_PITCH_ANG_GAIN, CFG_UNUSED_IDX, CFG_FIRST_SPARE},
                '{32'h0000_8000, 32'h0002_0000, 32'hFFFF_0000, 32'h0001_8000,
                  32'h7FFF_FFFF, 32'h8000_0000});
    pending_samples.push_back('0);
    pending_samples.push_back(fill('{32'h0000_0001, 0, 0, 0, 0, 0}));
    pending_samples.push_back(fill('{0, 0, 0, 0, 32'hFFFF_FFFF, 32'h0000_0001}));
    pending_samples.push_back({6{32'h7FFF_FFFF}});
    pending_samples.push_back({6{32'h8000_0000}});
    pending_samples.push_back(fill('{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}));
    pending_samples.push_back(fill('{32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
                                     32'hFFFF_0000, 32'h0000_4000, 32'hFFFF_C000}));
    pending_samples.push_back(fill('{0, 0, 32'h0000_0010, 32'h0000_0010, 0, 0}));
    pending_samples.push_back(fill('{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA,
                                     32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555}));
    wait_drained();

    g = '{32'h0000_8000, 32'h0002_0000, 32'h0001_0000, 32'h0003_0000};
    random_phase(g, 1'b0);
    random_phase('{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF}, 1'b0);
    random_phase('{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000}, 1'b0);
    for (int k = 0; k < 4; k++) g[k] = $urandom;
    random_phase(g, 1'b1);
    for (int k = 0; k < 4; k++) g[k] = DW'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
    random_phase(g, 1'b0);
    calm = 1'b1;
    for (int k = 0; k < 4; k++) g[k] = DW'(int'($urandom_range(0, 1 << 18)) - (1 << 17));
    random_phase(g, 1'b0);

    $display("covered %0d samples, %0d drive pairs checked, over eight gain settings",
             samples_sent, drives_checked);
    $display("settings included zero, full-scale positive and negative and random gains");
    if (mismatches == 0) begin
      $display("sliding_mode_attitude_law_core_tb: done, clean");
    end else begin
      $display("sliding_mode_attitude_law_core_tb: done, errors");
    end
    $finish;
  end

endmodule
